FILE: rtl/rc_pwm_pulse_decoder_unit_assert.svh
// Assertion macros shared by the pulse decoder RTL modules.
// The macros expect signals named clk and rst_n in the calling scope.
`ifndef RC_PWM_PULSE_DECODER_UNIT_ASSERT_SVH
`define RC_PWM_PULSE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpd assertion failed");
`define RPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpd assertion failed");
`else
`define RPD_ASSERT_SAME(label, ante, cons)
`define RPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/rpd_pkg.sv
// Package of the RC PWM pulse decoder: widths, register indexes and shared types.
// Depends on nothing; every RTL module and interface imports it.
`default_nettype none

package rpd_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_SLOTS   = 4;
    localparam int CH_USED      = (NUM_CHANNELS < CHAN_SLOTS) ? NUM_CHANNELS : CHAN_SLOTS;
    localparam int CH_IDX_W     = (CH_USED > 1) ? $clog2(CH_USED) : 1;

    localparam int CH_W      = 3;
    localparam int TIME_W    = 32;
    localparam int TICK_W    = 8;
    localparam int PULSE_W   = 19;
    localparam int VAL_W     = 32;
    localparam int RANGE_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam int US_LEGAL_MIN = 500;
    localparam int US_LEGAL_MAX = 2500;
    localparam int US_MAP_MIN   = 1000;
    localparam int US_MAP_MAX   = 2000;
    localparam int TICKS_RESET  = 84;

    localparam int TH_W      = 20;
    localparam int SPAN_W    = 18;
    localparam int REM_W     = SPAN_W + 1;
    localparam int FRAC_W    = 17;
    localparam int FRAC_SH   = 16;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = FRAC_W + 1 + DIFF_W;
    localparam int DIV_STEPS = FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CH1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CH4 = 3'd6;

    typedef struct packed {
        logic [TICK_W-1:0]                    ticks_per_us;
        logic                                 invert_polarity;
        logic [CHAN_SLOTS-1:0]                enable_mask;
        logic [CHAN_SLOTS-1:0][RANGE_W-1:0]   ranges;
    } rpd_cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic mul;
        logic fin;
    } rpd_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic out_busy;
    } rpd_status_t;

endpackage

`default_nettype wire

FILE: rtl/rpd_capture_if.sv
// Capture edge channel: valid/ready handshake with channel, timestamp and pin level.
// Depends on rpd_pkg.
`default_nettype none

interface rpd_capture_if;
    import rpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel_num;
    logic [TIME_W-1:0] capture_time;
    logic              pin_level;

    modport source (output valid, output channel_num, output capture_time,
                    output pin_level, input ready);
    modport sink (input valid, input channel_num, input capture_time,
                  input pin_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpd_pulse_if.sv
// Decoded pulse channel: valid/ready handshake with channel, ticks and mapped value.
// Depends on rpd_pkg.
`default_nettype none

interface rpd_pulse_if;
    import rpd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         out_channel;
    logic [PULSE_W-1:0]      pulse_ticks;
    logic signed [VAL_W-1:0] mapped_value;

    modport source (output valid, output out_channel, output pulse_ticks,
                    output mapped_value, input ready);
    modport sink (input valid, input out_channel, input pulse_ticks,
                  input mapped_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpd_cfg_regs.sv
// Configuration register file of the pulse decoder, written through a plain write port.
// Depends on rpd_pkg.
`default_nettype none

module rpd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpd_pkg::RANGE_W-1:0]    cfg_wdata,
    output rpd_pkg::rpd_cfg_t                   cfg
);
    import rpd_pkg::*;

    rpd_cfg_t                 cfg_reg;
    logic [CFG_IDX_W-1:0]     slot_full;
    logic [1:0]               slot;

    assign slot_full = cfg_index - REG_RANGE_CH1;
    assign slot      = slot_full[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us    <= TICK_W'(TICKS_RESET);
            cfg_reg.invert_polarity <= 1'b0;
            cfg_reg.enable_mask     <= '0;
            cfg_reg.ranges          <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TICKS:
                begin
                    cfg_reg.ticks_per_us <= cfg_wdata[TICK_W-1:0];
                end
                REG_INVERT:
                begin
                    cfg_reg.invert_polarity <= cfg_wdata[0];
                end
                REG_ENABLE:
                begin
                    cfg_reg.enable_mask <= cfg_wdata[CHAN_SLOTS-1:0];
                end
                default:
                begin
                    if (cfg_index inside {[REG_RANGE_CH1:REG_RANGE_CH4]})
                    begin
                        cfg_reg.ranges[slot] <= cfg_wdata;
                    end
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/rpd_ctrl.sv
// Sequencing state machine of the pulse decoder: accept, evaluate, divide, multiply, emit.
// Depends on rpd_pkg and the assertion macro header.
`default_nettype none
`include "rc_pwm_pulse_decoder_unit_assert.svh"

module rpd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  rpd_pkg::rpd_status_t       status,
    output rpd_pkg::rpd_cmd_t          cmd
);
    import rpd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.load     = in_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval  = 1'b1;
                step_next = '0;
                state_next = status.emit_ok ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `RPD_ASSERT_NEXT(a_drop_returns_idle, (state_reg == S_EVAL) && !status.emit_ok, state_reg == S_IDLE)
    `RPD_ASSERT_NEXT(a_div_ends_in_mul, (state_reg == S_DIV) && (step_reg == CNT_W'(DIV_STEPS - 1)), state_reg == S_MUL)
    `RPD_ASSERT_NEXT(a_fin_waits_on_busy, (state_reg == S_FIN) && status.out_busy, (state_reg == S_FIN) && !in_ready)

endmodule

`default_nettype wire

FILE: rtl/rpd_datapath.sv
// Datapath of the pulse decoder: channel history, thresholds, serial divider,
// range multiplier and output register. Depends on rpd_pkg and the assertion header.
`default_nettype none
`include "rc_pwm_pulse_decoder_unit_assert.svh"

module rpd_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  rpd_pkg::rpd_cfg_t                     cfg,
    input  rpd_pkg::rpd_cmd_t                     cmd,
    output rpd_pkg::rpd_status_t                  status,
    input  wire logic [rpd_pkg::CH_W-1:0]         in_channel,
    input  wire logic [rpd_pkg::TIME_W-1:0]       in_time,
    input  wire logic                             in_level,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [rpd_pkg::CH_W-1:0]              out_channel,
    output logic [rpd_pkg::PULSE_W-1:0]           out_ticks,
    output logic signed [rpd_pkg::VAL_W-1:0]      out_value
);
    import rpd_pkg::*;

    logic [CH_W-1:0]         ch_reg;
    logic [TIME_W-1:0]       time_reg;
    logic                    lvl_reg;

    logic [TIME_W-1:0]       prev_time_reg [CH_USED];
    logic [CH_USED-1:0]      prev_level_reg;
    logic [CH_USED-1:0]      seen_reg;

    logic [REM_W-1:0]        rem_reg;
    logic [SPAN_W-1:0]       span_reg;
    logic [FRAC_W-1:0]       q_reg;
    logic [PULSE_W-1:0]      ticks_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                    out_valid_reg;
    logic [CH_W-1:0]         out_ch_reg;
    logic [PULSE_W-1:0]      out_ticks_reg;
    logic [VAL_W-1:0]        out_val_reg;

    logic [CH_W-1:0]         ch_dec;
    logic [CH_IDX_W-1:0]     idx;
    logic                    ch_ok;
    logic                    active;
    logic                    pulse;
    logic [TIME_W-1:0]       high;
    logic [TH_W-1:0]         legal_lo;
    logic [TH_W-1:0]         legal_hi;
    logic [TH_W-1:0]         map_lo;
    logic [TH_W-1:0]         map_hi;
    logic                    legal;
    logic [TH_W-1:0]         hc;
    logic [TH_W-1:0]         rem0;
    logic [TH_W-1:0]         span0;

    logic                    ge;
    logic [REM_W-1:0]        rem_sub;

    logic [RANGE_W-1:0]      rng;
    logic signed [DIFF_W-1:0] mn_x;
    logic signed [DIFF_W-1:0] mx_x;
    logic signed [DIFF_W-1:0] diff;
    logic signed [FRAC_W:0]  frac_s;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] scaled;
    logic [DIFF_W-1:0]       val;

    assign ch_dec = ch_reg - CH_W'(1);
    assign idx    = ch_dec[CH_IDX_W-1:0];
    assign ch_ok  = (ch_reg != '0) && (ch_reg <= CH_W'(CH_USED));
    assign active = ~cfg.invert_polarity;
    assign pulse  = seen_reg[idx] && (prev_level_reg[idx] == active) && (lvl_reg != active);
    assign high   = time_reg - prev_time_reg[idx];

    assign legal_lo = TH_W'(cfg.ticks_per_us) * TH_W'(US_LEGAL_MIN);
    assign legal_hi = TH_W'(cfg.ticks_per_us) * TH_W'(US_LEGAL_MAX);
    assign map_lo   = TH_W'(cfg.ticks_per_us) * TH_W'(US_MAP_MIN);
    assign map_hi   = TH_W'(cfg.ticks_per_us) * TH_W'(US_MAP_MAX);

    assign legal = (high >= TIME_W'(legal_lo)) && (high <= TIME_W'(legal_hi));

    always_comb
    begin
        if (high < TIME_W'(map_lo))
        begin
            hc = map_lo;
        end
        else if (high > TIME_W'(map_hi))
        begin
            hc = map_hi;
        end
        else
        begin
            hc = high[TH_W-1:0];
        end
    end

    assign rem0  = hc - map_lo;
    assign span0 = map_hi - map_lo;

    assign status.emit_ok  = ch_ok && pulse && legal && cfg.enable_mask[idx];
    assign status.out_busy = out_valid_reg && !out_ready;

    assign ge      = (rem_reg >= REM_W'(span_reg));
    assign rem_sub = ge ? (rem_reg - REM_W'(span_reg)) : rem_reg;

    assign rng    = cfg.ranges[idx];
    assign mn_x   = DIFF_W'($signed(rng[VAL_W-1:0]));
    assign mx_x   = DIFF_W'($signed(rng[RANGE_W-1:VAL_W]));
    assign diff   = mx_x - mn_x;
    assign frac_s = (span_reg == '0) ? '0 : $signed({1'b0, q_reg});
    assign prod_c = PROD_W'(frac_s) * PROD_W'(diff);

    assign scaled = prod_reg[PROD_W-1]
                    ? ((prod_reg + PROD_W'((1 << FRAC_SH) - 1)) >>> FRAC_SH)
                    : (prod_reg >>> FRAC_SH);
    assign val    = mn_x + scaled[DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg   <= in_channel;
            time_reg <= in_time;
            lvl_reg  <= in_level;
        end
        if (cmd.eval)
        begin
            rem_reg   <= REM_W'(rem0);
            span_reg  <= span0[SPAN_W-1:0];
            q_reg     <= '0;
            ticks_reg <= hc[PULSE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
            q_reg   <= {q_reg[FRAC_W-2:0], ge};
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.fin)
        begin
            out_ch_reg    <= ch_reg;
            out_ticks_reg <= ticks_reg;
            out_val_reg   <= val[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_USED; i++)
            begin
                prev_time_reg[i] <= '0;
            end
            prev_level_reg <= '0;
            seen_reg       <= '0;
        end
        else if (cmd.eval && ch_ok)
        begin
            prev_time_reg[idx]  <= time_reg;
            prev_level_reg[idx] <= lvl_reg;
            seen_reg[idx]       <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign out_ticks   = out_ticks_reg;
    assign out_value   = $signed(out_val_reg);

    `RPD_ASSERT_NEXT(a_fin_fills_output, cmd.fin, out_valid_reg)
    `RPD_ASSERT_SAME(a_out_channel_legal, out_valid_reg, (out_ch_reg != '0) && (out_ch_reg <= CH_W'(CH_USED)))

endmodule

`default_nettype wire

FILE: rtl/rc_pwm_pulse_decoder_unit.sv
// RC PWM pulse decoder: per-channel capture edges in, decoded and mapped pulse widths out.
// Top level: connects the interfaces, the register file, the controller and the datapath.
// Each capture beat carries a channel number, a 32-bit timer value and the pin level.
// A falling edge of the active level on a channel with an earlier sample gives a pulse;
// a pulse inside the legal window on an enabled channel leaves as one beat on the pulse
// channel, with the clamped width in ticks and the value mapped into the channel range.
// After accepting a beat the block takes no new beat until it returns to idle: a beat
// that yields nothing returns right after evaluation, an emitting beat after the
// 17-step restoring divider, one quotient bit per cycle, then a multiply step and an
// output step that loads the output register.
// The finished result sits in an output register, so a new capture beat is accepted
// while it waits. If the receiver stalls, the next result holds in the final step
// until the output register frees, and capture ready stays low meanwhile.
// Reset clears the channel history and the output valid flag and loads the register
// defaults (84 ticks per microsecond, active-high, all channels disabled, ranges zero).
// Configuration writes are taken in one cycle and must happen while the block is idle.
`default_nettype none

module rc_pwm_pulse_decoder_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpd_pkg::RANGE_W-1:0]    cfg_wdata,
    rpd_capture_if.sink                         capture,
    rpd_pulse_if.source                         pulse
);
    import rpd_pkg::*;

    rpd_cfg_t    cfg;
    rpd_cmd_t    cmd;
    rpd_status_t status;
    logic        in_ready;

    rpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (capture.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rpd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .in_channel  (capture.channel_num),
        .in_time     (capture.capture_time),
        .in_level    (capture.pin_level),
        .out_valid   (pulse.valid),
        .out_ready   (pulse.ready),
        .out_channel (pulse.out_channel),
        .out_ticks   (pulse.pulse_ticks),
        .out_value   (pulse.mapped_value)
    );

    assign capture.ready = in_ready;

endmodule

`default_nettype wire
